### hw/rtl/fpfa_pkg.sv
// Shared types and constants for the fixed partition fit allocator.
`timescale 1ns / 1ps
`default_nettype none

package fpfa_pkg;

    localparam int PARTITIONS   = 16;
    localparam int SIZE_BITS    = 16;
    localparam int PROCESS_BITS = 8;

    localparam int IDX_W   = $clog2(PARTITIONS);
    localparam int LIM_W   = $clog2(PARTITIONS + 1);
    localparam int REQ_W   = 16;
    localparam int PID_W   = 8;
    localparam int PIDX_W  = 4;
    localparam int CMP_W   = (SIZE_BITS > REQ_W) ? SIZE_BITS : REQ_W;

    localparam int MODE_W  = 2;
    localparam int PARTS_W = 5;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [PARTS_W-1:0] PARTS_RESET = PARTS_W'(16);

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_ALLOC = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [MODE_W-1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2
    } fit_mode_t;

    localparam logic REG_FIT_MODE      = 1'b0;
    localparam logic REG_PARTS_IN_USE  = 1'b1;

    typedef struct packed {
        logic [1:0]        op;
        logic [PIDX_W-1:0] part_index;
        logic [REQ_W-1:0]  req_size;
        logic [PID_W-1:0]  process_id;
    } in_item_t;

    typedef struct packed {
        logic              found;
        logic [PIDX_W-1:0] granted_index;
        logic              is_taken;
        logic [PID_W-1:0]  owner_id;
        logic [REQ_W-1:0]  stored_size;
    } out_item_t;

    typedef struct packed {
        logic                    size_we;
        logic [IDX_W-1:0]        size_waddr;
        logic [SIZE_BITS-1:0]    size_wdata;
        logic                    grant;
        logic [IDX_W-1:0]        grant_idx;
        logic [PROCESS_BITS-1:0] owner_wdata;
        logic                    clear_all;
        logic [IDX_W-1:0]        rd_addr;
    } tbl_req_t;

    typedef struct packed {
        logic [SIZE_BITS-1:0]    size;
        logic                    taken;
        logic [PROCESS_BITS-1:0] owner;
    } tbl_rd_t;

    typedef struct packed {
        logic              start;
        logic              cand_valid;
        logic [MODE_W-1:0] mode;
    } fit_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/fpfa_table.sv
// Partition table: size and owner memories, taken flags, registered read port.
`timescale 1ns / 1ps
`default_nettype none

module fpfa_table (
    input  wire                clk,
    input  wire                rst_n,
    input  fpfa_pkg::tbl_req_t req,
    output fpfa_pkg::tbl_rd_t  rd
);
    import fpfa_pkg::*;

    logic [SIZE_BITS-1:0]    size_mem [PARTITIONS];
    logic [PROCESS_BITS-1:0] owner_mem [PARTITIONS];
    logic [PARTITIONS-1:0]   taken_reg;
    logic [PARTITIONS-1:0]   taken_next;
    tbl_rd_t                 rd_reg;

    always_comb
    begin
        taken_next = taken_reg;
        if (req.clear_all)
        begin
            taken_next = '0;
        end
        else if (req.grant)
        begin
            taken_next[req.grant_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg <= '0;
        end
        else
        begin
            taken_reg <= taken_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.size_we)
        begin
            size_mem[req.size_waddr] <= req.size_wdata;
        end
        if (req.grant)
        begin
            owner_mem[req.grant_idx] <= req.owner_wdata;
        end
        rd_reg.size  <= size_mem[req.rd_addr];
        rd_reg.owner <= owner_mem[req.rd_addr];
        rd_reg.taken <= taken_reg[req.rd_addr];
    end

    assign rd = rd_reg;

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        req.clear_all |=> (taken_reg == '0))
        else $error("taken flags survive a clear");

    a_grant_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (req.grant && !req.clear_all) |=> taken_reg[$past(req.grant_idx)])
        else $error("granted partition not marked taken");

    a_flags_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (!req.clear_all && !req.grant) |=> $stable(taken_reg))
        else $error("taken flags changed without grant or clear");

endmodule

`default_nettype wire

### hw/rtl/fpfa_fit_unit.sv
// Shared subtract and compare unit that tracks the best candidate during a scan.
`timescale 1ns / 1ps
`default_nettype none

module fpfa_fit_unit (
    input  wire                           clk,
    input  wire                           rst_n,
    input  fpfa_pkg::fit_ctrl_t           ctrl,
    input  wire [fpfa_pkg::SIZE_BITS-1:0] cand_size,
    input  wire                           cand_taken,
    input  wire [fpfa_pkg::IDX_W-1:0]     cand_idx,
    input  wire [fpfa_pkg::REQ_W-1:0]     need,
    output logic                          have,
    output logic [fpfa_pkg::IDX_W-1:0]    pick
);
    import fpfa_pkg::*;

    logic             have_reg, have_next;
    logic [CMP_W-1:0] best_reg, best_next;
    logic [IDX_W-1:0] pick_reg, pick_next;
    logic [CMP_W:0]   diff;
    logic             fits;
    logic [CMP_W-1:0] left;
    logic [CMP_W-1:0] size_x;
    logic             better;
    logic             take;

    always_comb
    begin
        size_x = CMP_W'(cand_size);
        diff   = {1'b0, size_x} - {1'b0, CMP_W'(need)};
        fits   = !diff[CMP_W] && !cand_taken;
        left   = diff[CMP_W-1:0];
        case (ctrl.mode)
            FIT_BEST:  better = (best_reg >= left);
            FIT_WORST: better = (size_x >= best_reg);
            default:   better = 1'b0;
        endcase
        take = ctrl.cand_valid && fits && (!have_reg || better);

        have_next = have_reg;
        best_next = best_reg;
        pick_next = pick_reg;
        if (ctrl.start)
        begin
            have_next = 1'b0;
        end
        else if (take)
        begin
            have_next = 1'b1;
            pick_next = cand_idx;
            best_next = (ctrl.mode == FIT_BEST) ? left : size_x;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else
        begin
            have_reg <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        pick_reg <= pick_next;
    end

    assign have = have_reg;
    assign pick = pick_reg;

endmodule

`default_nettype wire

### hw/rtl/fixed_partition_fit_allocator_top.sv
// Top level: APB registers, operation sequencer and output register.
// Usage:
//   in_valid/in_ready/in_data carry one operation beat (load size, clear all,
//   allocate, read). out_valid/out_ready/out_data return exactly one result
//   beat for every operation accepted, in order.
//   in_ready is high only while the sequencer is idle; one operation is in
//   flight at a time, so a new beat is taken only after the previous result
//   has moved into the output register. Load and clear go straight to the
//   completion step, read passes through a table read step, and allocate
//   scans partitions 0 to limit - 1, where limit is partitions_in_use capped
//   at the table depth, then grants. The scan reads one partition per cycle
//   from the table's single read port into the shared compare unit.
//   The output register holds a result until taken; a new operation may be
//   accepted while it waits, and its own result waits in the sequencer until
//   the output register frees.
//   Reset clears all taken flags, sets fit_mode to first fit and
//   partitions_in_use to 16. Partition sizes are unknown until loaded.
//   The user must write the APB port (fit_mode at 0x0, partitions_in_use at
//   0x4) only while the block is idle; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module fixed_partition_fit_allocator_top (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  fpfa_pkg::in_item_t           in_data,
    output logic                         out_valid,
    input  wire                          out_ready,
    output fpfa_pkg::out_item_t          out_data,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [fpfa_pkg::PADDR_W-1:0]  paddr,
    input  wire [fpfa_pkg::PDATA_W-1:0]  pwdata,
    output logic [fpfa_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import fpfa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_GRANT,
        S_READ,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [PARTS_W-1:0] parts_reg, parts_next;
    in_item_t          item_reg, item_next;
    out_item_t         res_reg, res_next;
    out_item_t         out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    logic [LIM_W-1:0]  cnt_reg, cnt_next;
    logic              issue_reg, issue_next;
    logic [IDX_W-1:0]  cand_idx_reg, cand_idx_next;

    logic              accept;
    logic              cfg_we;
    logic [LIM_W-1:0]  limit;
    logic              in_range;
    tbl_req_t          treq;
    tbl_rd_t           trd;
    fit_ctrl_t         fctrl;
    logic              fit_have;
    logic [IDX_W-1:0]  fit_pick;

    fpfa_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (treq),
        .rd    (trd)
    );

    fpfa_fit_unit u_fit (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (fctrl),
        .cand_size  (trd.size),
        .cand_taken (trd.taken),
        .cand_idx   (cand_idx_reg),
        .need       (item_reg.req_size),
        .have       (fit_have),
        .pick       (fit_pick)
    );

    assign pready    = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_we    = psel && penable && pwrite;
    assign limit     = (32'(parts_reg) > PARTITIONS) ? LIM_W'(PARTITIONS) : LIM_W'(parts_reg);

    always_comb
    begin
        case (paddr[2])
            REG_FIT_MODE:     prdata = PDATA_W'(mode_reg);
            REG_PARTS_IN_USE: prdata = PDATA_W'(parts_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        parts_next     = parts_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        cnt_next       = cnt_reg;
        issue_next     = 1'b0;
        cand_idx_next  = cand_idx_reg;
        in_range       = (32'(item_reg.part_index) < PARTITIONS);

        treq             = '0;
        treq.size_waddr  = IDX_W'(in_data.part_index);
        treq.size_wdata  = SIZE_BITS'(in_data.req_size);
        treq.grant_idx   = fit_pick;
        treq.owner_wdata = PROCESS_BITS'(item_reg.process_id);
        treq.rd_addr     = cnt_reg[IDX_W-1:0];

        fctrl            = '0;
        fctrl.mode       = mode_reg;
        fctrl.cand_valid = issue_reg;

        if (cfg_we)
        begin
            case (paddr[2])
                REG_FIT_MODE:     mode_next  = pwdata[MODE_W-1:0];
                REG_PARTS_IN_USE: parts_next = pwdata[PARTS_W-1:0];
                default:          mode_next  = mode_reg;
            endcase
        end

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                treq.rd_addr = IDX_W'(in_data.part_index);
                if (accept)
                begin
                    item_next = in_data;
                    res_next  = '0;
                    case (op_t'(in_data.op))
                        OP_LOAD:
                        begin
                            treq.size_we = (32'(in_data.part_index) < PARTITIONS);
                            state_next   = S_DONE;
                        end
                        OP_CLEAR:
                        begin
                            treq.clear_all = 1'b1;
                            state_next     = S_DONE;
                        end
                        OP_ALLOC:
                        begin
                            cnt_next    = '0;
                            fctrl.start = 1'b1;
                            state_next  = S_SCAN;
                        end
                        OP_READ:
                        begin
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (cnt_reg < limit)
                begin
                    issue_next    = 1'b1;
                    cand_idx_next = cnt_reg[IDX_W-1:0];
                    cnt_next      = cnt_reg + LIM_W'(1);
                end
                else
                begin
                    state_next = S_GRANT;
                end
            end
            S_GRANT:
            begin
                if (fit_have)
                begin
                    treq.grant             = 1'b1;
                    res_next.found         = 1'b1;
                    res_next.granted_index = PIDX_W'(fit_pick);
                end
                state_next = S_DONE;
            end
            S_READ:
            begin
                if (in_range)
                begin
                    res_next.granted_index = item_reg.part_index;
                    res_next.is_taken      = trd.taken;
                    res_next.owner_id      = trd.taken ? PID_W'(trd.owner) : '0;
                    res_next.stored_size   = REQ_W'(trd.size);
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= FIT_FIRST;
            parts_reg     <= PARTS_RESET;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            issue_reg     <= 1'b0;
            item_reg      <= '0;
            res_reg       <= '0;
            out_reg       <= '0;
            cand_idx_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            parts_reg     <= parts_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            issue_reg     <= issue_next;
            item_reg      <= item_next;
            res_reg       <= res_next;
            out_reg       <= out_next;
            cand_idx_reg  <= cand_idx_next;
        end
    end

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("second beat accepted while an operation is in flight");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (cnt_reg <= limit))
        else $error("scan counter ran past the partition limit");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result beat raised outside the completion step");

    a_grant_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GRANT) |=> (res_reg.found == $past(fit_have)))
        else $error("allocate result disagrees with the fit unit");

endmodule

`default_nettype wire

### test/fixed_partition_fit_allocator_top_test.sv
// Testbench for the fixed partition fit allocator: predicts every result beat and checks it.
`timescale 1ns / 1ps

module fixed_partition_fit_allocator_top_test;
    import fpfa_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_ITEMS   = 100;
    localparam int RANDOM_PHASES = 12;
    localparam int MAX_REPORTS   = 200;
    localparam int SETTLE_CYCLES = 24;

    localparam logic [PADDR_W-1:0] ADDR_FIT_MODE     = PADDR_W'(4 * REG_FIT_MODE);
    localparam logic [PADDR_W-1:0] ADDR_PARTS_IN_USE = PADDR_W'(4 * REG_PARTS_IN_USE);
    localparam logic [MODE_W-1:0]  FIT_UNUSED        = 2'd3;

    localparam logic [MODE_W-1:0] PHASE_MODE [RANDOM_PHASES] = '{
        FIT_FIRST, FIT_BEST, FIT_WORST, FIT_UNUSED, FIT_WORST, FIT_BEST,
        FIT_FIRST, FIT_WORST, FIT_BEST, FIT_UNUSED, FIT_WORST, FIT_FIRST
    };
    localparam logic [PARTS_W-1:0] PHASE_PARTS [RANDOM_PHASES] = '{
        5'd16, 5'd16, 5'd16, 5'd31, 5'd1, 5'd0, 5'd7, 5'd16, 5'd2, 5'd20, 5'd12, 5'd16
    };
    localparam logic [REQ_W-1:0] SEED_SIZES [PARTITIONS] = '{
        16'd0, 16'hFFFF, 16'd100, 16'd100, 16'd50, 16'd200, 16'd100, 16'd7,
        16'd1, 16'h8000, 16'd100, 16'd3, 16'hFFFF, 16'd12, 16'd100, 16'd255
    };

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    in_item_t          in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    out_item_t         out_data;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr    = '0;
    logic [PDATA_W-1:0] pwdata   = '0;
    logic [PDATA_W-1:0] prdata;
    logic              pready;

    logic [REQ_W-1:0]        part_size  [PARTITIONS];
    logic                    part_taken [PARTITIONS];
    logic [PROCESS_BITS-1:0] part_owner [PARTITIONS];
    logic [MODE_W-1:0]       cur_mode  = FIT_FIRST;
    logic [PARTS_W-1:0]      cur_parts = PARTS_RESET;

    in_item_t  op_queue [$];
    out_item_t awaited_results [$];
    int        ops_queued   = 0;
    int        ops_accepted = 0;
    int        errors       = 0;
    int        cfg_errors   = 0;
    int        cycles       = 0;
    int        send_idle    = 0;
    int        recv_idle    = 0;
    logic      in_fire      = 1'b0;

    fixed_partition_fit_allocator_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic out_item_t apply_table_op(in_item_t op_beat);
        out_item_t        res;
        int               limit;
        int               pick;
        int               i;
        logic             have;
        logic [REQ_W-1:0] best;
        res   = '0;
        pick  = 0;
        have  = 1'b0;
        best  = '0;
        limit = (cur_parts > PARTITIONS) ? PARTITIONS : int'(cur_parts);
        case (op_beat.op)
            OP_LOAD:
            begin
                part_size[op_beat.part_index] = op_beat.req_size;
            end
            OP_CLEAR:
            begin
                for (i = 0; i < PARTITIONS; i++)
                begin
                    part_taken[i] = 1'b0;
                end
            end
            OP_ALLOC:
            begin
                for (i = 0; i < limit; i++)
                begin
                    if (!part_taken[i] && part_size[i] >= op_beat.req_size)
                    begin
                        if (cur_mode == FIT_BEST)
                        begin
                            if (!have || (part_size[i] - op_beat.req_size) <= best)
                            begin
                                best = part_size[i] - op_beat.req_size;
                                pick = i;
                                have = 1'b1;
                            end
                        end
                        else if (cur_mode == FIT_WORST)
                        begin
                            if (!have || part_size[i] >= best)
                            begin
                                best = part_size[i];
                                pick = i;
                                have = 1'b1;
                            end
                        end
                        else if (!have)
                        begin
                            pick = i;
                            have = 1'b1;
                        end
                    end
                end
                if (have)
                begin
                    part_taken[pick]  = 1'b1;
                    part_owner[pick]  = op_beat.process_id;
                    res.found         = 1'b1;
                    res.granted_index = PIDX_W'(pick);
                end
            end
            OP_READ:
            begin
                res.granted_index = op_beat.part_index;
                res.is_taken      = part_taken[op_beat.part_index];
                res.owner_id      = part_taken[op_beat.part_index] ?
                                    part_owner[op_beat.part_index] : '0;
                res.stored_size   = part_size[op_beat.part_index];
            end
            default:
            begin
                res = '0;
            end
        endcase
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
            begin
                $display("%0t: %s mismatch, expected %0h actual %0h",
                         $time, name, want_v, got_v);
            end
        end
    endtask

    function automatic void queue_op(input logic [1:0] op, input logic [PIDX_W-1:0] idx,
                                     input logic [REQ_W-1:0] size,
                                     input logic [PID_W-1:0] pid);
        in_item_t op_beat;
        op_beat.op         = op;
        op_beat.part_index = idx;
        op_beat.req_size   = size;
        op_beat.process_id = pid;
        op_queue.push_back(op_beat);
        ops_queued++;
    endfunction

    function automatic logic [REQ_W-1:0] rand_size();
        int kind;
        kind = $urandom_range(99);
        if (kind < 35)
            return REQ_W'($urandom_range(20));
        else if (kind < 65)
            return REQ_W'($urandom_range(300));
        else if (kind < 70)
            return '0;
        else if (kind < 75)
            return '1;
        else
            return REQ_W'($urandom);
    endfunction

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input int value);
        logic [PDATA_W-1:0] readback;
        readback = (addr == ADDR_FIT_MODE) ? PDATA_W'(value[MODE_W-1:0])
                                           : PDATA_W'(value[PARTS_W-1:0]);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata !== readback || pready !== 1'b1)
        begin
            cfg_errors++;
            $display("%0t: register readback mismatch, expected %0h actual %0h",
                     $time, readback, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        while (!(ops_accepted == ops_queued && awaited_results.size() == 0))
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_fire)
        begin
            if (op_queue.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                in_data  <= op_queue.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin : monitor
        out_item_t want;
        in_fire <= in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $display("%0t: unexpected result beat, expected none actual %h",
                             $time, out_data);
                end
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("found", 32'(want.found), 32'(out_data.found));
                check_field("granted_index", 32'(want.granted_index),
                            32'(out_data.granted_index));
                check_field("is_taken", 32'(want.is_taken), 32'(out_data.is_taken));
                check_field("owner_id", 32'(want.owner_id), 32'(out_data.owner_id));
                check_field("stored_size", 32'(want.stored_size),
                            32'(out_data.stored_size));
            end
        end
        if (rst_n && in_valid && in_ready)
        begin
            awaited_results.push_back(apply_table_op(in_data));
            ops_accepted <= ops_accepted + 1;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int ph;
        int k;
        int kind;
        logic [1:0] op;
        for (k = 0; k < PARTITIONS; k++)
        begin
            part_size[k]  = '0;
            part_taken[k] = 1'b0;
            part_owner[k] = '0;
        end
        send_idle = 7;
        recv_idle = 74;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // load every partition before any search or read touches it
        for (k = 0; k < PARTITIONS; k++)
        begin
            queue_op(OP_LOAD, PIDX_W'(k), SEED_SIZES[k], PID_W'($urandom));
        end
        queue_op(OP_ALLOC, 4'hF, 16'd0, 8'hFF);
        queue_op(OP_ALLOC, 4'h0, 16'hFFFF, 8'h00);
        queue_op(OP_ALLOC, 4'h5, 16'd100, 8'hA5);
        queue_op(OP_ALLOC, 4'hA, 16'hFFFF, 8'h5A);
        queue_op(OP_ALLOC, 4'h3, 16'hFFFF, 8'h3C);
        queue_op(OP_READ, 4'h2, 16'hFFFF, 8'hFF);
        queue_op(OP_READ, 4'hF, 16'h0000, 8'h00);
        queue_op(OP_LOAD, 4'h2, 16'h5555, 8'hC3);
        queue_op(OP_READ, 4'h2, 16'hAAAA, 8'h0F);
        queue_op(OP_CLEAR, 4'hF, 16'hFFFF, 8'hFF);
        queue_op(OP_READ, 4'h2, 16'h0000, 8'hF0);
        wait_drained();

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph < 4)
            begin
                send_idle = 7;
                recv_idle = 74;
            end
            else if (ph < 8)
            begin
                send_idle = 74;
                recv_idle = 7;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            apb_write(ADDR_FIT_MODE, int'(PHASE_MODE[ph]));
            cur_mode = PHASE_MODE[ph];
            apb_write(ADDR_PARTS_IN_USE, int'(PHASE_PARTS[ph]));
            cur_parts = PHASE_PARTS[ph];
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                kind = $urandom_range(99);
                if (kind < 40)
                    op = OP_ALLOC;
                else if (kind < 62)
                    op = OP_READ;
                else if (kind < 88)
                    op = OP_LOAD;
                else
                    op = OP_CLEAR;
                queue_op(op, PIDX_W'($urandom), rand_size(), PID_W'($urandom));
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && cfg_errors == 0 && awaited_results.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
